// ----- rtl/pps_pkg.sv -----
package pps_pkg;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_PROCESSES = 16;
    localparam int DEF_TIME_BITS     = 16;

    // Fixed field widths.
    localparam int ID_W   = 8;
    localparam int PRIO_W = 8;

    // Request operation codes.
    localparam logic OP_ADD  = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // Per-cell command from the sequencer.
    typedef struct packed {
        logic load;
        logic run;
    } pps_cmd_t;

endpackage

// ----- rtl/pps_cell.sv -----
module pps_cell #(
    parameter int TIME_BITS = pps_pkg::DEF_TIME_BITS,
    parameter int IDX_W     = 4,
    parameter int CELL_IDX  = 0
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  pps_pkg::pps_cmd_t           cmd,
    input  logic [pps_pkg::ID_W-1:0]    load_id,
    input  logic [TIME_BITS-1:0]        load_arrival,
    input  logic [TIME_BITS-1:0]        load_burst,
    input  logic [pps_pkg::PRIO_W-1:0]  load_prio,
    input  logic [TIME_BITS-1:0]        now_time,
    input  logic                        smallest_first,
    input  logic                        in_found,
    input  logic [IDX_W-1:0]            in_idx,
    input  logic [pps_pkg::PRIO_W-1:0]  in_prio,
    input  logic [TIME_BITS-1:0]        in_arrival,
    input  logic [pps_pkg::ID_W-1:0]    in_id,
    input  logic [TIME_BITS-1:0]        in_burst,
    input  logic [TIME_BITS-1:0]        in_remaining,
    input  logic                        in_started,
    input  logic [TIME_BITS-1:0]        in_start_time,
    output logic                        out_found,
    output logic [IDX_W-1:0]            out_idx,
    output logic [pps_pkg::PRIO_W-1:0]  out_prio,
    output logic [TIME_BITS-1:0]        out_arrival,
    output logic [pps_pkg::ID_W-1:0]    out_id,
    output logic [TIME_BITS-1:0]        out_burst,
    output logic [TIME_BITS-1:0]        out_remaining,
    output logic                        out_started,
    output logic [TIME_BITS-1:0]        out_start_time,
    output logic                        valid
);

    logic                       valid_reg;
    logic                       started_reg;
    logic [pps_pkg::ID_W-1:0]   id_reg;
    logic [TIME_BITS-1:0]       arrival_reg;
    logic [TIME_BITS-1:0]       remaining_reg;
    logic [TIME_BITS-1:0]       burst_reg;
    logic [pps_pkg::PRIO_W-1:0] prio_reg;
    logic [TIME_BITS-1:0]       start_time_reg;

    logic                       found_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [pps_pkg::PRIO_W-1:0] c_prio_reg;
    logic [TIME_BITS-1:0]       c_arrival_reg;
    logic [pps_pkg::ID_W-1:0]   c_id_reg;
    logic [TIME_BITS-1:0]       c_burst_reg;
    logic [TIME_BITS-1:0]       c_remaining_reg;
    logic                       c_started_reg;
    logic [TIME_BITS-1:0]       c_start_time_reg;

    logic eligible;
    logic prio_better;
    logic take;

    assign eligible    = valid_reg && (arrival_reg <= now_time);
    assign prio_better = smallest_first ? (prio_reg < in_prio) : (prio_reg > in_prio);
    // The incoming candidate comes from lower slots, so it keeps a full tie.
    assign take = eligible && (!in_found ||
                  ((prio_reg != in_prio) ? prio_better : (arrival_reg < in_arrival)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            started_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            found_reg <= in_found || take;
            if (cmd.load)
            begin
                valid_reg   <= 1'b1;
                started_reg <= 1'b0;
            end
            else if (cmd.run)
            begin
                if (remaining_reg == TIME_BITS'(1))
                begin
                    valid_reg   <= 1'b0;
                    started_reg <= 1'b0;
                end
                else
                begin
                    started_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            id_reg        <= load_id;
            arrival_reg   <= load_arrival;
            remaining_reg <= load_burst;
            burst_reg     <= load_burst;
            prio_reg      <= load_prio;
        end
        else if (cmd.run)
        begin
            remaining_reg <= remaining_reg - TIME_BITS'(1);
            if (!started_reg)
            begin
                start_time_reg <= now_time;
            end
        end

        if (take)
        begin
            idx_reg          <= IDX_W'(CELL_IDX);
            c_prio_reg       <= prio_reg;
            c_arrival_reg    <= arrival_reg;
            c_id_reg         <= id_reg;
            c_burst_reg      <= burst_reg;
            c_remaining_reg  <= remaining_reg;
            c_started_reg    <= started_reg;
            c_start_time_reg <= start_time_reg;
        end
        else
        begin
            idx_reg          <= in_idx;
            c_prio_reg       <= in_prio;
            c_arrival_reg    <= in_arrival;
            c_id_reg         <= in_id;
            c_burst_reg      <= in_burst;
            c_remaining_reg  <= in_remaining;
            c_started_reg    <= in_started;
            c_start_time_reg <= in_start_time;
        end
    end

    assign out_found      = found_reg;
    assign out_idx        = idx_reg;
    assign out_prio       = c_prio_reg;
    assign out_arrival    = c_arrival_reg;
    assign out_id         = c_id_reg;
    assign out_burst      = c_burst_reg;
    assign out_remaining  = c_remaining_reg;
    assign out_started    = c_started_reg;
    assign out_start_time = c_start_time_reg;
    assign valid          = valid_reg;

endmodule

// ----- rtl/preemptive_priority_scheduler.sv -----
// Add request: no result, the block stays idle. IO add: busy in the finish state, and the
// result strobe is registered from that state. Tick: the best entry is found by a candidate
// passed one cell per cycle along the slot chain while searching; the run state then moves
// time on, and only when the chosen entry finishes does the block pass through the finish
// state, from which the result strobe is registered. The receiver cannot stall.
// Reset empties the table, clears time to zero and selects smallest-number-first.
module preemptive_priority_scheduler #(
    parameter int MAX_PROCESSES = pps_pkg::DEF_MAX_PROCESSES,
    parameter int TIME_BITS     = pps_pkg::DEF_TIME_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic                        op,
    input  logic [pps_pkg::ID_W-1:0]    proc_id,
    input  logic [TIME_BITS-1:0]        arrival_at,
    input  logic [TIME_BITS-1:0]        burst_length,
    input  logic [pps_pkg::PRIO_W-1:0]  prio_level,
    input  logic                        is_io,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        smallest_first,
    output logic                        done,
    output logic [pps_pkg::ID_W-1:0]    done_id,
    output logic [TIME_BITS-1:0]        completion_at,
    output logic [TIME_BITS-1:0]        response_len,
    output logic [TIME_BITS-1:0]        turnaround_len,
    output logic [TIME_BITS-1:0]        waiting_len
);

    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_RUN    = 2'd2;
    localparam logic [1:0] ST_FIN    = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [IDX_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     cnt_next;
    logic [TIME_BITS-1:0] now_reg;
    logic [TIME_BITS-1:0] now_next;
    logic                 smallest_first_reg;

    logic [pps_pkg::ID_W-1:0] res_id_reg;
    logic [TIME_BITS-1:0]     res_comp_reg;
    logic [TIME_BITS-1:0]     res_resp_reg;
    logic [TIME_BITS-1:0]     res_arr_reg;
    logic [TIME_BITS-1:0]     res_burst_reg;

    logic                     done_reg;
    logic [pps_pkg::ID_W-1:0] done_id_reg;
    logic [TIME_BITS-1:0]     completion_reg;
    logic [TIME_BITS-1:0]     response_reg;
    logic [TIME_BITS-1:0]     turnaround_reg;
    logic [TIME_BITS-1:0]     waiting_reg;

    logic                       ch_found      [0:MAX_PROCESSES];
    logic [IDX_W-1:0]           ch_idx        [0:MAX_PROCESSES];
    logic [pps_pkg::PRIO_W-1:0] ch_prio       [0:MAX_PROCESSES];
    logic [TIME_BITS-1:0]       ch_arrival    [0:MAX_PROCESSES];
    logic [pps_pkg::ID_W-1:0]   ch_id         [0:MAX_PROCESSES];
    logic [TIME_BITS-1:0]       ch_burst      [0:MAX_PROCESSES];
    logic [TIME_BITS-1:0]       ch_remaining  [0:MAX_PROCESSES];
    logic                       ch_started    [0:MAX_PROCESSES];
    logic [TIME_BITS-1:0]       ch_start_time [0:MAX_PROCESSES];

    logic [MAX_PROCESSES-1:0] cell_valid;
    logic [MAX_PROCESSES-1:0] free_vec;
    logic [MAX_PROCESSES-1:0] free_onehot;

    logic                 accept;
    logic                 add_fire;
    logic                 run_fire;
    logic [TIME_BITS-1:0] now_inc;
    logic [TIME_BITS:0]   io_sum;
    logic [TIME_BITS-1:0] io_comp;
    logic [TIME_BITS-1:0] run_resp;
    logic [TIME_BITS-1:0] fin_turn;
    logic [TIME_BITS-1:0] fin_wait;

    assign accept   = start && !busy;
    assign add_fire = accept && (op == pps_pkg::OP_ADD) && !is_io &&
                      (burst_length != '0);
    assign run_fire = (state_reg == ST_RUN) && ch_found[MAX_PROCESSES];

    // Lowest free slot as a one-hot vector; zero when the table is full.
    assign free_vec    = ~cell_valid;
    assign free_onehot = free_vec & (~free_vec + MAX_PROCESSES'(1));

    assign now_inc  = (&now_reg) ? now_reg : (now_reg + TIME_BITS'(1));
    assign io_sum   = {1'b0, arrival_at} + {1'b0, burst_length};
    assign io_comp  = io_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : io_sum[TIME_BITS-1:0];

    always_comb
    begin
        if (ch_started[MAX_PROCESSES])
        begin
            run_resp = (ch_start_time[MAX_PROCESSES] > ch_arrival[MAX_PROCESSES]) ?
                       (ch_start_time[MAX_PROCESSES] - ch_arrival[MAX_PROCESSES]) : '0;
        end
        else
        begin
            run_resp = (now_reg > ch_arrival[MAX_PROCESSES]) ?
                       (now_reg - ch_arrival[MAX_PROCESSES]) : '0;
        end
    end

    assign fin_turn = (res_comp_reg > res_arr_reg) ? (res_comp_reg - res_arr_reg) : '0;
    assign fin_wait = (fin_turn > res_burst_reg) ? (fin_turn - res_burst_reg) : '0;

    // The chain starts each pass with no candidate.
    assign ch_found[0]      = 1'b0;
    assign ch_idx[0]        = '0;
    assign ch_prio[0]       = '0;
    assign ch_arrival[0]    = '0;
    assign ch_id[0]         = '0;
    assign ch_burst[0]      = '0;
    assign ch_remaining[0]  = '0;
    assign ch_started[0]    = 1'b0;
    assign ch_start_time[0] = '0;

    for (genvar g = 0; g < MAX_PROCESSES; g++)
    begin : g_cell
        pps_pkg::pps_cmd_t cmd;

        assign cmd.load = add_fire && free_onehot[g];
        assign cmd.run  = run_fire && (ch_idx[MAX_PROCESSES] == IDX_W'(g));

        pps_cell #(
            .TIME_BITS (TIME_BITS),
            .IDX_W     (IDX_W),
            .CELL_IDX  (g)
        ) u_cell (
            .clk            (clk),
            .rst_n          (rst_n),
            .cmd            (cmd),
            .load_id        (proc_id),
            .load_arrival   (arrival_at),
            .load_burst     (burst_length),
            .load_prio      (prio_level),
            .now_time       (now_reg),
            .smallest_first (smallest_first_reg),
            .in_found       (ch_found[g]),
            .in_idx         (ch_idx[g]),
            .in_prio        (ch_prio[g]),
            .in_arrival     (ch_arrival[g]),
            .in_id          (ch_id[g]),
            .in_burst       (ch_burst[g]),
            .in_remaining   (ch_remaining[g]),
            .in_started     (ch_started[g]),
            .in_start_time  (ch_start_time[g]),
            .out_found      (ch_found[g+1]),
            .out_idx        (ch_idx[g+1]),
            .out_prio       (ch_prio[g+1]),
            .out_arrival    (ch_arrival[g+1]),
            .out_id         (ch_id[g+1]),
            .out_burst      (ch_burst[g+1]),
            .out_remaining  (ch_remaining[g+1]),
            .out_started    (ch_started[g+1]),
            .out_start_time (ch_start_time[g+1]),
            .valid          (cell_valid[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        now_next   = now_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == pps_pkg::OP_TICK)
                    begin
                        state_next = ST_SEARCH;
                        cnt_next   = '0;
                    end
                    else if (is_io)
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (cnt_reg == IDX_W'(MAX_PROCESSES - 1))
                begin
                    state_next = ST_RUN;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_RUN:
            begin
                now_next = now_inc;
                if (run_fire && (ch_remaining[MAX_PROCESSES] == TIME_BITS'(1)))
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FIN:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg          <= ST_IDLE;
            cnt_reg            <= '0;
            now_reg            <= '0;
            smallest_first_reg <= 1'b1;
            done_reg           <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            now_reg   <= now_next;
            done_reg  <= (state_reg == ST_FIN);
            if (cfg_valid && cfg_ready)
            begin
                smallest_first_reg <= smallest_first;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && accept && (op == pps_pkg::OP_ADD) && is_io)
        begin
            res_id_reg    <= proc_id;
            res_comp_reg  <= io_comp;
            res_resp_reg  <= '0;
            res_arr_reg   <= arrival_at;
            res_burst_reg <= burst_length;
        end
        else if (run_fire)
        begin
            res_id_reg    <= ch_id[MAX_PROCESSES];
            res_comp_reg  <= now_inc;
            res_resp_reg  <= run_resp;
            res_arr_reg   <= ch_arrival[MAX_PROCESSES];
            res_burst_reg <= ch_burst[MAX_PROCESSES];
        end

        if (state_reg == ST_FIN)
        begin
            done_id_reg    <= res_id_reg;
            completion_reg <= res_comp_reg;
            response_reg   <= res_resp_reg;
            turnaround_reg <= fin_turn;
            waiting_reg    <= fin_wait;
        end
    end

    assign busy           = (state_reg != ST_IDLE);
    // The ordering may only change between requests, never during a search.
    assign cfg_ready      = !busy;
    assign done           = done_reg;
    assign done_id        = done_id_reg;
    assign completion_at  = completion_reg;
    assign response_len   = response_reg;
    assign turnaround_len = turnaround_reg;
    assign waiting_len    = waiting_reg;

`ifndef SYNTHESIS
    a_done_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while a request is still in progress");

    a_run_valid_slot: assert property (@(posedge clk) disable iff (!rst_n)
        run_fire |-> cell_valid[ch_idx[MAX_PROCESSES]])
        else $error("chosen slot is not occupied");

    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RUN) |=> (now_reg == $past(now_reg)))
        else $error("time moved outside a tick");

    a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
        else $error("block became busy without a request");
`endif

endmodule
